// ----- hw/rtl/one_euro_axis_filter_top_macros.svh -----
// Assertion helpers used by the filter controller.
`ifndef ONE_EURO_AXIS_FILTER_TOP_MACROS_SVH
`define ONE_EURO_AXIS_FILTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OEF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("one euro filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define OEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("one euro filter check failed");

`endif

// ----- hw/rtl/oef_pkg.sv -----
`timescale 1ns / 1ps

package oef_pkg;

   localparam int AXIS_COUNT       = 6;
   localparam int FIRST_ANGLE_AXIS = 3;
   localparam int AXIS_W           = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FC_MIN_POS  = 3'd0,
      CSR_BETA_POS    = 3'd1,
      CSR_DCUT_POS    = 3'd2,
      CSR_FC_MIN_ROT  = 3'd3,
      CSR_BETA_ROT    = 3'd4,
      CSR_DCUT_ROT    = 3'd5
   } csr_index_type;

   localparam logic [15:0] FC_MIN_RESET = 16'd256;
   localparam logic [15:0] DCUT_RESET   = 16'd256;
   localparam logic [23:0] BETA_RESET   = 24'd0;

   localparam logic [19:0] MIN_STEP_US   = 20'd100;
   localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
   localparam logic [18:0] TWO_PI_Q16    = 19'd411775;
   localparam logic [59:0] ALPHA_SCALE   = 60'd16777216000000;
   localparam logic [16:0] ALPHA_ONE     = 17'd65536;
   localparam logic [19:0] FC_LIMIT      = 20'hFFFFF;
   localparam logic [34:0] DEG180        = 35'd11796480;
   localparam logic [34:0] DEG360        = 35'd23592960;
   // 256 turns: lifts any difference of two 32-bit values above zero.
   localparam logic [35:0] WRAP_OFFSET   = 36'd6039797760;
   localparam logic [3:0]  WRAP_TOP_SHIFT = 4'd8;
   localparam logic [5:0]  DX_DIV_STEPS    = 6'd53;
   localparam logic [5:0]  ALPHA_DIV_STEPS = 6'd17;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_READ,
      OP_WRAP_INIT,
      OP_WRAP_STEP,
      OP_WRAP_END,
      OP_DX_INIT,
      OP_DIV_STEP,
      OP_DX_END,
      OP_ALPHA_MUL1,
      OP_ALPHA_MUL2,
      OP_ALPHA_DEN,
      OP_ALPHA_END,
      OP_SLOPE_MUL,
      OP_SLOPE_ADD,
      OP_FC_MUL,
      OP_FC_ADD,
      OP_VALUE_MUL,
      OP_VALUE_ADD,
      OP_FIN_PASS,
      OP_FIN_HOLD,
      OP_FIN_FIRST,
      OP_FIN_FILTER
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       sel_second;
      logic       wrap_value;
      logic [3:0] wrap_k;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic short_step;
      logic started;
      logic angle;
   } dp_status_type;

   // One full turn scaled by 2^k, for the binary reduction of an angle.
   function automatic logic [34:0] wrap_const(input logic [3:0] k);
      return DEG360 << k;
   endfunction

endpackage

// ----- hw/rtl/oef_if.sv -----
`timescale 1ns / 1ps

interface oef_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         axis_index;
   logic signed [31:0] sample;
   logic [19:0]        delta_time_us;

   modport source (output valid, axis_index, sample, delta_time_us, input ready);
   modport sink   (input valid, axis_index, sample, delta_time_us, output ready);
endinterface

interface oef_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         out_axis;
   logic signed [31:0] filtered_value;
   logic               held;

   modport source (output valid, out_axis, filtered_value, held, input ready);
   modport sink   (input valid, out_axis, filtered_value, held, output ready);
endinterface

interface oef_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/oef_datapath.sv -----
`timescale 1ns / 1ps

module oef_datapath import oef_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [2:0]             in_axis_index,
   input  logic signed [31:0]     in_sample,
   input  logic [19:0]            in_delta_time_us,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [2:0]             out_axis,
   output logic signed [31:0]     out_filtered_value,
   output logic                   out_held
);

   logic [15:0] fc_min_pos_ff, dcut_pos_ff, fc_min_rot_ff, dcut_rot_ff;
   logic [23:0] beta_pos_ff, beta_rot_ff;
   logic [AXIS_COUNT-1:0] started_ff;

   logic signed [31:0] smoothed_mem [AXIS_COUNT];
   logic signed [31:0] slope_mem [AXIS_COUNT];

   logic [2:0]         axis_ff;
   logic signed [31:0] raw_ff;
   logic [19:0]        dt_ff;
   logic signed [31:0] prev_ff, slope_ff, dx_ff;
   logic signed [32:0] diff_ff;
   logic signed [33:0] value_ff;
   logic [34:0]        wm_ff;
   logic [52:0]        dvd_ff, quo_ff;
   logic [44:0]        rem_ff;
   logic [43:0]        dvs_ff;
   logic               neg_ff;
   logic [39:0]        prod40_ff;
   logic [58:0]        num_ff;
   logic [16:0]        alpha_ff;
   logic signed [50:0] mprod_ff;
   logic [31:0]        mag_ff;
   logic [55:0]        bprod_ff;
   logic [19:0]        fc_ff;
   logic [2:0]         rsp_axis_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_held_ff;

   logic [AXIS_W-1:0]  idx;
   logic [AXIS_W-1:0]  in_idx;
   logic [4:0]         axis_ext;
   logic [15:0]        grp_fc_min, grp_dcut;
   logic [23:0]        grp_beta;
   logic signed [32:0] diff_calc;
   logic signed [33:0] wrap_src;
   logic [35:0]        wrap_sum;
   logic [34:0]        wrap_c;
   logic [35:0]        fold;
   logic [32:0]        diff_abs;
   logic [44:0]        div_t;
   logic               div_ge;
   logic [59:0]        den_sum;
   logic [19:0]        fc_pick;
   logic signed [17:0] alpha_s;
   logic signed [32:0] sdiff;
   logic signed [50:0] mshift;
   logic signed [50:0] slope_sum, value_sum;
   logic [32:0]        fc_sum;
   logic [31:0]        dx_calc;

   assign idx      = AXIS_W'(axis_ff);
   assign in_idx   = AXIS_W'(in_axis_index);
   assign axis_ext = 5'(axis_ff);

   always_comb begin
      status.in_range   = axis_ext < 5'(AXIS_COUNT);
      status.angle      = axis_ext >= 5'(FIRST_ANGLE_AXIS);
      status.short_step = dt_ff <= MIN_STEP_US;
      status.started    = status.in_range && started_ff[idx];
   end

   assign grp_fc_min = status.angle ? fc_min_rot_ff : fc_min_pos_ff;
   assign grp_dcut   = status.angle ? dcut_rot_ff : dcut_pos_ff;
   assign grp_beta   = status.angle ? beta_rot_ff : beta_pos_ff;

   always_comb begin
      diff_calc   = {raw_ff[31], raw_ff} - {prev_ff[31], prev_ff};
      wrap_src    = cmd.wrap_value ? value_ff : {diff_ff[32], diff_ff};
      wrap_sum    = {{2{wrap_src[33]}}, wrap_src} + WRAP_OFFSET;
      wrap_c      = wrap_const(cmd.wrap_k);
      fold        = {1'b0, wm_ff} - ((wm_ff > DEG180) ? {1'b0, DEG360} : 36'd0);
      diff_abs    = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
      div_t       = {rem_ff[43:0], dvd_ff[52]};
      div_ge      = div_t >= {1'b0, dvs_ff};
      den_sum     = {1'b0, num_ff} + ALPHA_SCALE;
      fc_pick     = cmd.sel_second ? fc_ff : {4'd0, grp_dcut};
      alpha_s     = $signed({1'b0, alpha_ff});
      sdiff       = {dx_ff[31], dx_ff} - {slope_ff[31], slope_ff};
      mshift      = mprod_ff >>> 16;
      slope_sum   = {{19{slope_ff[31]}}, slope_ff} + mshift;
      value_sum   = {{19{prev_ff[31]}}, prev_ff} + mshift;
      fc_sum      = {17'd0, grp_fc_min} + {1'b0, bprod_ff[55:24]};
      if (neg_ff) begin
         dx_calc = (quo_ff > 53'h80000000) ? 32'h80000000 : 32'(-quo_ff[31:0]);
      end else begin
         dx_calc = (quo_ff > 53'h7FFFFFFF) ? 32'h7FFFFFFF : quo_ff[31:0];
      end
   end

   // Configuration and per-axis started flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_min_pos_ff <= FC_MIN_RESET;
         beta_pos_ff   <= BETA_RESET;
         dcut_pos_ff   <= DCUT_RESET;
         fc_min_rot_ff <= FC_MIN_RESET;
         beta_rot_ff   <= BETA_RESET;
         dcut_rot_ff   <= DCUT_RESET;
         started_ff    <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_FC_MIN_POS: fc_min_pos_ff <= csr_data[15:0];
               CSR_BETA_POS:   beta_pos_ff   <= csr_data;
               CSR_DCUT_POS:   dcut_pos_ff   <= csr_data[15:0];
               CSR_FC_MIN_ROT: fc_min_rot_ff <= csr_data[15:0];
               CSR_BETA_ROT:   beta_rot_ff   <= csr_data;
               CSR_DCUT_ROT:   dcut_rot_ff   <= csr_data[15:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_FIN_FIRST) begin
            started_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            axis_ff  <= in_axis_index;
            raw_ff   <= in_sample;
            dt_ff    <= in_delta_time_us;
            prev_ff  <= smoothed_mem[in_idx];
            slope_ff <= slope_mem[in_idx];
         end
         OP_READ: begin
            diff_ff <= diff_calc;
         end
         OP_WRAP_INIT: wm_ff <= wrap_sum[34:0];
         OP_WRAP_STEP: begin
            if (wm_ff >= wrap_c) begin
               wm_ff <= wm_ff - wrap_c;
            end
         end
         OP_WRAP_END: begin
            if (cmd.wrap_value) begin
               value_ff <= $signed(fold[33:0]);
            end else begin
               diff_ff <= $signed(fold[32:0]);
            end
         end
         OP_DX_INIT: begin
            dvd_ff <= diff_abs * USEC_PER_SEC;
            rem_ff <= '0;
            dvs_ff <= 44'(dt_ff);
            quo_ff <= '0;
            neg_ff <= diff_ff[32];
         end
         OP_DIV_STEP: begin
            rem_ff <= div_ge ? (div_t - {1'b0, dvs_ff}) : div_t;
            dvd_ff <= {dvd_ff[51:0], 1'b0};
            quo_ff <= {quo_ff[51:0], div_ge};
         end
         OP_DX_END:     dx_ff <= dx_calc;
         OP_ALPHA_MUL1: prod40_ff <= fc_pick * dt_ff;
         OP_ALPHA_MUL2: num_ff <= prod40_ff * TWO_PI_Q16;
         OP_ALPHA_DEN: begin
            dvs_ff <= den_sum[59:16];
            rem_ff <= 45'(num_ff[58:17]);
            dvd_ff <= {num_ff[16:0], 36'd0};
            quo_ff <= '0;
         end
         OP_ALPHA_END: alpha_ff <= (quo_ff[16:0] > ALPHA_ONE) ? ALPHA_ONE : quo_ff[16:0];
         OP_SLOPE_MUL: mprod_ff <= alpha_s * sdiff;
         OP_SLOPE_ADD: begin
            slope_ff <= slope_sum[31:0];
            mag_ff   <= slope_sum[31] ? 32'(-slope_sum[31:0]) : slope_sum[31:0];
         end
         OP_FC_MUL: bprod_ff <= grp_beta * mag_ff;
         OP_FC_ADD: fc_ff <= (fc_sum > {13'd0, FC_LIMIT}) ? FC_LIMIT : fc_sum[19:0];
         OP_VALUE_MUL: mprod_ff <= alpha_s * diff_ff;
         OP_VALUE_ADD: value_ff <= value_sum[33:0];
         OP_FIN_PASS: begin
            rsp_axis_ff  <= axis_ff;
            rsp_value_ff <= raw_ff;
            rsp_held_ff  <= 1'b0;
         end
         OP_FIN_HOLD: begin
            rsp_axis_ff  <= axis_ff;
            rsp_value_ff <= status.started ? prev_ff : raw_ff;
            rsp_held_ff  <= 1'b1;
         end
         OP_FIN_FIRST: begin
            smoothed_mem[idx] <= raw_ff;
            slope_mem[idx]    <= '0;
            rsp_axis_ff       <= axis_ff;
            rsp_value_ff      <= raw_ff;
            rsp_held_ff       <= 1'b0;
         end
         OP_FIN_FILTER: begin
            smoothed_mem[idx] <= value_ff[31:0];
            slope_mem[idx]    <= slope_ff;
            rsp_axis_ff       <= axis_ff;
            rsp_value_ff      <= value_ff[31:0];
            rsp_held_ff       <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign out_axis           = rsp_axis_ff;
   assign out_filtered_value = rsp_value_ff;
   assign out_held           = rsp_held_ff;

endmodule

// ----- hw/rtl/oef_ctrl.sv -----
`timescale 1ns / 1ps
`include "one_euro_axis_filter_top_macros.svh"

module oef_ctrl import oef_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [20:0] {
      S_IDLE      = 21'd1 << 0,
      S_DECIDE    = 21'd1 << 1,
      S_WRAP_INIT = 21'd1 << 2,
      S_WRAP_STEP = 21'd1 << 3,
      S_WRAP_END  = 21'd1 << 4,
      S_DX_INIT   = 21'd1 << 5,
      S_DX_DIV    = 21'd1 << 6,
      S_DX_END    = 21'd1 << 7,
      S_A_MUL1    = 21'd1 << 8,
      S_A_MUL2    = 21'd1 << 9,
      S_A_DEN     = 21'd1 << 10,
      S_A_DIV     = 21'd1 << 11,
      S_A_END     = 21'd1 << 12,
      S_SL_MUL    = 21'd1 << 13,
      S_SL_ADD    = 21'd1 << 14,
      S_FC_MUL    = 21'd1 << 15,
      S_FC_ADD    = 21'd1 << 16,
      S_V_MUL     = 21'd1 << 17,
      S_V_ADD     = 21'd1 << 18,
      S_FINISH    = 21'd1 << 19,
      S_SPARE     = 21'd1 << 20
   } state_type;

   typedef enum logic [1:0] {
      FIN_PASS,
      FIN_HOLD,
      FIN_FIRST,
      FIN_FILTER
   } fin_type;

   state_type  state_ff, state_in;
   fin_type    fin_ff, fin_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [3:0] wrap_k_ff, wrap_k_in;
   logic       second_ff, second_in;
   logic       wrap_val_ff, wrap_val_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      cnt_in       = cnt_ff;
      wrap_k_in    = wrap_k_ff;
      second_in    = second_ff;
      wrap_val_in  = wrap_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op         = OP_NONE;
      cmd.sel_second = second_ff;
      cmd.wrap_value = wrap_val_ff;
      cmd.wrap_k     = wrap_k_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.op      = OP_READ;
            second_in   = 1'b0;
            wrap_val_in = 1'b0;
            wrap_k_in   = WRAP_TOP_SHIFT;
            if (!status.in_range) begin
               fin_in   = FIN_PASS;
               state_in = S_FINISH;
            end else if (status.short_step) begin
               fin_in   = FIN_HOLD;
               state_in = S_FINISH;
            end else if (!status.started) begin
               fin_in   = FIN_FIRST;
               state_in = S_FINISH;
            end else begin
               fin_in   = FIN_FILTER;
               state_in = status.angle ? S_WRAP_INIT : S_DX_INIT;
            end
         end
         S_WRAP_INIT: begin
            cmd.op   = OP_WRAP_INIT;
            state_in = S_WRAP_STEP;
         end
         S_WRAP_STEP: begin
            cmd.op = OP_WRAP_STEP;
            if (wrap_k_ff == '0) begin
               state_in = S_WRAP_END;
            end else begin
               wrap_k_in = wrap_k_ff - 4'd1;
            end
         end
         S_WRAP_END: begin
            cmd.op   = OP_WRAP_END;
            state_in = wrap_val_ff ? S_FINISH : S_DX_INIT;
         end
         S_DX_INIT: begin
            cmd.op   = OP_DX_INIT;
            cnt_in   = DX_DIV_STEPS - 6'd1;
            state_in = S_DX_DIV;
         end
         S_DX_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = S_DX_END;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_DX_END: begin
            cmd.op   = OP_DX_END;
            state_in = S_A_MUL1;
         end
         S_A_MUL1: begin
            cmd.op   = OP_ALPHA_MUL1;
            state_in = S_A_MUL2;
         end
         S_A_MUL2: begin
            cmd.op   = OP_ALPHA_MUL2;
            state_in = S_A_DEN;
         end
         S_A_DEN: begin
            cmd.op   = OP_ALPHA_DEN;
            cnt_in   = ALPHA_DIV_STEPS - 6'd1;
            state_in = S_A_DIV;
         end
         S_A_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = S_A_END;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_A_END: begin
            cmd.op   = OP_ALPHA_END;
            state_in = second_ff ? S_V_MUL : S_SL_MUL;
         end
         S_SL_MUL: begin
            cmd.op   = OP_SLOPE_MUL;
            state_in = S_SL_ADD;
         end
         S_SL_ADD: begin
            cmd.op   = OP_SLOPE_ADD;
            state_in = S_FC_MUL;
         end
         S_FC_MUL: begin
            cmd.op   = OP_FC_MUL;
            state_in = S_FC_ADD;
         end
         S_FC_ADD: begin
            cmd.op    = OP_FC_ADD;
            second_in = 1'b1;
            state_in  = S_A_MUL1;
         end
         S_V_MUL: begin
            cmd.op   = OP_VALUE_MUL;
            state_in = S_V_ADD;
         end
         S_V_ADD: begin
            cmd.op = OP_VALUE_ADD;
            if (status.angle) begin
               wrap_val_in = 1'b1;
               wrap_k_in   = WRAP_TOP_SHIFT;
               state_in    = S_WRAP_INIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               case (fin_ff)
                  FIN_PASS:  cmd.op = OP_FIN_PASS;
                  FIN_HOLD:  cmd.op = OP_FIN_HOLD;
                  FIN_FIRST: cmd.op = OP_FIN_FIRST;
                  default:   cmd.op = OP_FIN_FILTER;
               endcase
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fin_ff       <= FIN_PASS;
         cnt_ff       <= '0;
         wrap_k_ff    <= '0;
         second_ff    <= 1'b0;
         wrap_val_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         cnt_ff       <= cnt_in;
         wrap_k_ff    <= wrap_k_in;
         second_ff    <= second_in;
         wrap_val_ff  <= wrap_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `OEF_ASSERT_NEXT(a_accept_decides, clock, reset, req_valid && req_ready, state_ff == S_DECIDE)
   `OEF_ASSERT_NOW(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH)
   `OEF_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == S_DX_DIV && cnt_ff == '0, state_ff == S_DX_END)
   `OEF_ASSERT_NOW(a_wrap_bound, clock, reset, state_ff == S_WRAP_STEP, wrap_k_ff <= WRAP_TOP_SHIFT)

endmodule

// ----- hw/rtl/one_euro_axis_filter_top.sv -----
`timescale 1ns / 1ps
// Channel   Role      Content
// req_ch    sink      axis_index, sample (Q16.16), delta_time_us
// rsp_ch    source    out_axis, filtered_value (Q16.16), held
// csr_ch    sink      register index, write data (always ready)
//
// A filtered sample passes through the 53-step derivative division and the two 17-step
// alpha divisions on the shared restoring divider; an angle also wraps its difference
// and its result. Pass-through, held and first samples skip all of these steps.
// Reset is synchronous and active high; it restores the register defaults and clears
// every axis. A result waits in the output register while the next item is taken in.

module one_euro_axis_filter_top import oef_pkg::*; (
   input logic       clock,
   input logic       reset,
   oef_req_if.sink   req_ch,
   oef_rsp_if.source rsp_ch,
   oef_csr_if.sink   csr_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller sequences one item at a time through the datapath.
   oef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Register writes are taken unchecked; the user must issue them only while idle.
   assign csr_ch.ready = 1'b1;

   oef_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_axis_index      (req_ch.axis_index),
      .in_sample          (req_ch.sample),
      .in_delta_time_us   (req_ch.delta_time_us),
      .csr_write          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .out_axis           (rsp_ch.out_axis),
      .out_filtered_value (rsp_ch.filtered_value),
      .out_held           (rsp_ch.held)
   );

endmodule
